// ----- hw/rtl/word_packet_deframer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Word packet deframer assertion macros
// Concurrent assertion helpers shared by the deframer RTL. They expand to
// nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef WORD_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define WORD_PACKET_DEFRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds on every rising clock edge outside reset
`define WPD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("deframer property violated");
// Check that an expression is never true outside reset
`define WPD_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("deframer forbidden condition seen");
`else
`define WPD_ASSERT(lbl, clk, rstn, prop)
`define WPD_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ----- hw/rtl/wpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Word packet deframer package
// Phase codes, header layout constants, the per-beat result record and the
// clamp helper shared by the deframer modules.
// ----------------------------------------------------------------------------
package wpd_pkg;

  // Parse phase; the code doubles as the byte kind reported per beat
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_CONTENT = 2'd2,
    PH_TERM    = 2'd3
  } wpd_phase_e;

  // Header byte positions (zero based) that close each header field
  localparam logic [3:0] HDR_SEQ_LAST  = 4'd3;
  localparam logic [3:0] HDR_SIZE_LAST = 4'd7;
  localparam logic [3:0] HDR_LAST      = 4'd11;

  // Last byte of a 4-byte word length
  localparam logic [1:0] FIELD_LAST = 2'd3;

  // Sequence word layout
  localparam int unsigned FLAG_SERVER_BIT   = 31;
  localparam int unsigned FLAG_RESPONSE_BIT = 30;
  localparam logic [29:0] SEQ_MASK          = 30'h3FFF_FFFF;

  // One labeled beat as it leaves the block
  typedef struct packed {
    logic [1:0]         byte_kind;
    logic [7:0]         out_byte;
    logic [30:0]        word_index;
    logic [30:0]        offset_in_word;
    logic               header_done;
    logic               from_server;
    logic               is_response;
    logic [29:0]        sequence_number;
    logic signed [31:0] packet_size;
    logic [30:0]        word_total;
    logic [30:0]        word_length;
    logic               packet_end;
  } wpd_result_t;

  // Treat a negative 32-bit count or length as zero
  function automatic logic [30:0] clamp_nonneg(input logic [31:0] w);
    return w[31] ? 31'd0 : w[30:0];
  endfunction

endpackage

// ----- hw/rtl/word_packet_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// Word packet deframer
// Labels a packet byte stream one beat per byte: a 12-byte little-endian
// header (sequence word, size word, word count) followed by words made of a
// 4-byte length, the content bytes and a terminator byte. Every input beat
// yields exactly one result beat in the cycle after it is taken, and a new byte
// is taken in every cycle as long as the result register is free or
// draining; the parse state update and labeling of a byte fit in the single
// combinational pass in front of that register. Negative counts and lengths
// count as zero, and the size word is reported only.
// ----------------------------------------------------------------------------
`include "word_packet_deframer_unit_macros.svh"

module word_packet_deframer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         in_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         byte_kind_o,
  output logic [7:0]         out_byte_o,
  output logic [30:0]        word_index_o,
  output logic [30:0]        offset_in_word_o,
  output logic               header_done_o,
  output logic               from_server_o,
  output logic               is_response_o,
  output logic [29:0]        sequence_number_o,
  output logic signed [31:0] packet_size_o,
  output logic [30:0]        word_total_o,
  output logic [30:0]        word_length_o,
  output logic               packet_end_o
);
  import wpd_pkg::*;

  logic        fire;
  wpd_result_t core_res;
  wpd_result_t out_res;

  // Accept a beat when offered and not held
  assign fire = in_valid_i && !in_stall_o;

  wpd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .in_byte_i (in_byte_i),
    .res_o     (core_res)
  );

  wpd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .res_i       (core_res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .in_stall_o  (in_stall_o),
    .res_o       (out_res)
  );

  // Unpack the result beat onto the ports
  assign byte_kind_o       = out_res.byte_kind;
  assign out_byte_o        = out_res.out_byte;
  assign word_index_o      = out_res.word_index;
  assign offset_in_word_o  = out_res.offset_in_word;
  assign header_done_o     = out_res.header_done;
  assign from_server_o     = out_res.from_server;
  assign is_response_o     = out_res.is_response;
  assign sequence_number_o = out_res.sequence_number;
  assign packet_size_o     = out_res.packet_size;
  assign word_total_o      = out_res.word_total;
  assign word_length_o     = out_res.word_length;
  assign packet_end_o      = out_res.packet_end;

  // Header completion is only flagged on a header byte
  `WPD_ASSERT(a_hdone_on_header, clk_i, rst_ni, out_valid_o && header_done_o |-> byte_kind_o == PH_HEADER)
  // Offsets are only nonzero on content bytes
  `WPD_ASSERT(a_offset_content, clk_i, rst_ni, out_valid_o && byte_kind_o != PH_CONTENT |-> offset_in_word_o == 31'd0)
  // A packet never ends on a length or content byte
  `WPD_ASSERT_NEVER(a_end_kind, clk_i, rst_ni, out_valid_o && packet_end_o && (byte_kind_o == PH_LENGTH || byte_kind_o == PH_CONTENT))
  // Header fields stay blank until the header is complete
  `WPD_ASSERT(a_hdr_blank, clk_i, rst_ni, out_valid_o && byte_kind_o == PH_HEADER && !header_done_o |-> sequence_number_o == 30'd0 && word_total_o == 31'd0 && !packet_end_o)

endmodule

// ----- hw/rtl/wpd_core.sv -----
// ----------------------------------------------------------------------------
// Word packet deframer parse core
// Holds the parse state and labels the incoming byte in one pass of
// combinational logic; state advances on each accepted beat.
// ----------------------------------------------------------------------------
module wpd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          in_byte_i,
  output wpd_pkg::wpd_result_t res_o
);
  import wpd_pkg::*;

  wpd_phase_e  phase_q, phase_d;
  logic [1:0]  fbc_q, fbc_d;
  logic [3:0]  hbc_q, hbc_d;
  logic [31:0] assemble_q, assemble_d;
  logic [31:0] fas_q, fas_d;
  logic [31:0] size_q, size_d;
  logic [30:0] count_q, count_d;
  logic [30:0] cw_q, cw_d;
  logic [30:0] cl_q, cl_d;
  logic [30:0] cp_q, cp_d;

  logic [31:0] asm_shift;
  logic [30:0] asm_clamped;
  logic [31:0] next_word_cnt;
  logic        show_header;

  // Shift the new byte in at the top (little-endian assembly)
  assign asm_shift     = {in_byte_i, assemble_q[31:8]};
  assign asm_clamped   = clamp_nonneg(asm_shift);
  assign next_word_cnt = {1'b0, cw_q} + 32'd1;

  // Next state and per-beat labels
  always_comb begin
    phase_d    = phase_q;
    fbc_d      = fbc_q;
    hbc_d      = hbc_q;
    assemble_d = assemble_q;
    fas_d      = fas_q;
    size_d     = size_q;
    count_d    = count_q;
    cw_d       = cw_q;
    cl_d       = cl_q;
    cp_d       = cp_q;
    show_header = 1'b1;

    res_o                = '0;
    res_o.byte_kind      = phase_q;
    res_o.out_byte       = in_byte_i;

    case (phase_q)
      PH_HEADER: begin
        assemble_d = asm_shift;
        if (hbc_q == HDR_SEQ_LAST) begin
          fas_d = asm_shift;
        end else if (hbc_q == HDR_SIZE_LAST) begin
          size_d = asm_shift;
        end
        if (hbc_q >= HDR_LAST) begin
          count_d = asm_clamped;
          res_o.header_done = 1'b1;
          hbc_d = '0;
          cw_d  = '0;
          fbc_d = '0;
          if (asm_clamped == 31'd0) begin
            res_o.packet_end = 1'b1;
            phase_d = PH_HEADER;
          end else begin
            phase_d = PH_LENGTH;
          end
        end else begin
          hbc_d = hbc_q + 4'd1;
          show_header = 1'b0;
        end
      end
      PH_LENGTH: begin
        res_o.word_index = cw_q;
        assemble_d = asm_shift;
        if (fbc_q == FIELD_LAST) begin
          cl_d = asm_clamped;
          res_o.word_length = asm_clamped;
          fbc_d = '0;
          cp_d  = '0;
          phase_d = (asm_clamped == 31'd0) ? PH_TERM : PH_CONTENT;
        end else begin
          fbc_d = fbc_q + 2'd1;
        end
      end
      PH_CONTENT: begin
        res_o.word_index     = cw_q;
        res_o.word_length    = cl_q;
        res_o.offset_in_word = cp_q;
        cp_d = cp_q + 31'd1;
        if (cp_d >= cl_q) begin
          phase_d = PH_TERM;
        end
      end
      PH_TERM: begin
        res_o.word_index  = cw_q;
        res_o.word_length = cl_q;
        if (next_word_cnt >= {1'b0, count_q}) begin
          res_o.packet_end = 1'b1;
          phase_d = PH_HEADER;
          hbc_d   = '0;
          cw_d    = '0;
        end else begin
          cw_d    = next_word_cnt[30:0];
          phase_d = PH_LENGTH;
        end
        fbc_d = '0;
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase

    // Header fields read zero until the header is complete
    if (show_header) begin
      res_o.from_server     = fas_d[FLAG_SERVER_BIT];
      res_o.is_response     = fas_d[FLAG_RESPONSE_BIT];
      res_o.sequence_number = fas_d[29:0] & SEQ_MASK;
      res_o.packet_size     = $signed(size_d);
      res_o.word_total      = count_d;
    end
  end

  // Advance parse state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      fbc_q      <= '0;
      hbc_q      <= '0;
      assemble_q <= '0;
      fas_q      <= '0;
      size_q     <= '0;
      count_q    <= '0;
      cw_q       <= '0;
      cl_q       <= '0;
      cp_q       <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      fbc_q      <= fbc_d;
      hbc_q      <= hbc_d;
      assemble_q <= assemble_d;
      fas_q      <= fas_d;
      size_q     <= size_d;
      count_q    <= count_d;
      cw_q       <= cw_d;
      cl_q       <= cl_d;
      cp_q       <= cp_d;
    end
  end

endmodule

// ----- hw/rtl/wpd_out_stage.sv -----
// ----------------------------------------------------------------------------
// Word packet deframer output stage
// Result register with valid/stall handshake; takes a new beat whenever it is
// empty or its current beat is leaving in the same cycle.
// ----------------------------------------------------------------------------
module wpd_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  wpd_pkg::wpd_result_t res_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 in_stall_o,
  output wpd_pkg::wpd_result_t res_o
);
  import wpd_pkg::*;

  logic        out_valid_q, out_valid_d;
  wpd_result_t res_q;

  // Hold upstream only while a result is waiting and downstream stalls
  assign in_stall_o = out_valid_q && out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_i) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded with each accepted beat
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule
